@@ hw/rtl/mbfu_pkg.sv @@
package mbfu_pkg;

	localparam int unsigned WORD_WIDTH = 32;
	localparam int unsigned FIELD_MAX  = 16;
	localparam int unsigned HOLD_MAX   = FIELD_MAX - 1;
	localparam int unsigned ACC_WIDTH  = HOLD_MAX + WORD_WIDTH;
	localparam int unsigned ADDR_WIDTH = 4;

	typedef logic [4:0] width_t;
	typedef logic [5:0] count_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_FIRST_WIDTH  = 2'd0,
		REG_FIRST_COUNT  = 2'd1,
		REG_SECOND_WIDTH = 2'd2,
		REG_SECOND_COUNT = 2'd3
	} reg_index_t;

	localparam width_t WIDTH_RESET_FIRST  = 5'd12;
	localparam width_t WIDTH_RESET_SECOND = 5'd2;
	localparam count_t COUNT_RESET        = 6'd63;

	function automatic logic phase_open(input phase_t ph);
		return (ph == PH_FIRST) || (ph == PH_SECOND);
	endfunction

	// Zero acts as one, anything past sixteen acts as sixteen.
	function automatic width_t clamp_width(input width_t v);
		width_t r;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (v > 5'(FIELD_MAX)) begin
			r = 5'(FIELD_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic count_t clamp_count(input count_t v);
		return (v == 6'd0) ? 6'd1 : v;
	endfunction

	// Low w bits set, w in 1..16.
	function automatic logic [FIELD_MAX-1:0] field_mask(input width_t w);
		return {FIELD_MAX{1'b1}} >> (5'(FIELD_MAX) - w);
	endfunction

	// Low p bits set, p in 0..15.
	function automatic logic [HOLD_MAX-1:0] hold_mask(input logic [3:0] p);
		return {HOLD_MAX{1'b1}} >> (4'(HOLD_MAX) - p);
	endfunction

endpackage

@@ hw/rtl/msb_first_bit_field_unpacker.sv @@
// MSB-first bit field unpacker. Each 32-bit word is cut from its top bit down into
// fields of first_width bits (first_count of them), then second_width bits
// (second_count of them); a field that crosses a word boundary takes its high bits
// from the end of the earlier word. record_start clears the unpacker and opens the
// first table; words outside an open record are taken and give no result. One field
// leaves per cycle, while out_stall does not hold the output register, from a single
// shift-and-mask extractor working on a 47-bit window; a word stays in the extractor
// until the fields it completes (at most 32) have left. The next word is taken in
// the same cycle that the last field of the current word moves to the output register.
// Configuration registers sit at byte addresses 0, 4, 8, 12; the user must write them
// only while no record word is in flight, which the block itself does not enforce.
module msb_first_bit_field_unpacker (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mbfu_pkg::WORD_WIDTH-1:0] word_in,
	input  logic                            record_start,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     field_value,
	output logic                            table_select,
	output logic [5:0]                      field_index,
	output logic                            last_of_word,
	output logic                            record_done,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mbfu_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int unsigned AW = mbfu_pkg::ACC_WIDTH;

	// configuration
	mbfu_pkg::width_t first_width_q, second_width_q;
	mbfu_pkg::count_t first_count_q, second_count_q;
	mbfu_pkg::reg_index_t reg_sel;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = mbfu_pkg::reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_width_q  <= mbfu_pkg::WIDTH_RESET_FIRST;
			first_count_q  <= mbfu_pkg::COUNT_RESET;
			second_width_q <= mbfu_pkg::WIDTH_RESET_SECOND;
			second_count_q <= mbfu_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				mbfu_pkg::REG_FIRST_WIDTH:  first_width_q  <= pwdata[4:0];
				mbfu_pkg::REG_FIRST_COUNT:  first_count_q  <= pwdata[5:0];
				mbfu_pkg::REG_SECOND_WIDTH: second_width_q <= pwdata[4:0];
				mbfu_pkg::REG_SECOND_COUNT: second_count_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mbfu_pkg::REG_FIRST_WIDTH:  prdata = {27'd0, first_width_q};
			mbfu_pkg::REG_FIRST_COUNT:  prdata = {26'd0, first_count_q};
			mbfu_pkg::REG_SECOND_WIDTH: prdata = {27'd0, second_width_q};
			mbfu_pkg::REG_SECOND_COUNT: prdata = {26'd0, second_count_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// working state
	logic                busy_q;
	mbfu_pkg::phase_t    phase_q;
	logic [5:0]          counter_q;
	logic [4:0]          emit_q;
	logic [AW-1:0]       acc_q;
	logic [5:0]          n_q;

	// output register
	logic                out_valid_q;
	logic [15:0]         field_value_q;
	logic                table_select_q;
	logic [5:0]          field_index_q;
	logic                last_q;
	logic                done_q;

	// extraction of one field from the window
	logic                second;
	mbfu_pkg::width_t    w_cur;
	mbfu_pkg::count_t    cnt_cur;
	logic [AW-1:0]       shifted;
	logic [15:0]         value;
	logic [5:0]          n_post;
	logic                table_end;
	mbfu_pkg::phase_t    phase_post;
	logic [5:0]          counter_post;
	mbfu_pkg::width_t    w_post;
	logic                more;
	logic                fire;
	logic                accept;

	always_comb begin
		second    = (phase_q == mbfu_pkg::PH_SECOND);
		w_cur     = mbfu_pkg::clamp_width(second ? second_width_q : first_width_q);
		cnt_cur   = mbfu_pkg::clamp_count(second ? second_count_q : first_count_q);
		shifted   = acc_q >> (n_q - {1'b0, w_cur});
		value     = shifted[15:0] & mbfu_pkg::field_mask(w_cur);
		n_post    = n_q - {1'b0, w_cur};
		table_end = ({1'b0, counter_q} + 7'd1) >= {1'b0, cnt_cur};
		if (table_end) begin
			counter_post = 6'd0;
			phase_post   = second ? mbfu_pkg::PH_IDLE : mbfu_pkg::PH_SECOND;
		end else begin
			counter_post = counter_q + 6'd1;
			phase_post   = phase_q;
		end
		w_post = mbfu_pkg::clamp_width((phase_post == mbfu_pkg::PH_SECOND) ?
			second_width_q : first_width_q);
		more = mbfu_pkg::phase_open(phase_post) && (n_post >= {1'b0, w_post}) &&
			(emit_q != 5'd31);
	end

	assign fire     = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q && !(fire && !more);
	assign accept   = in_valid && !in_stall;

	// state seen by an incoming word: after this cycle's field if one leaves
	mbfu_pkg::phase_t    base_phase;
	logic [5:0]          base_counter;
	logic [5:0]          base_n;
	logic [3:0]          base_p;
	mbfu_pkg::phase_t    new_phase;
	logic [5:0]          new_counter;
	logic [3:0]          p_raw;
	logic [3:0]          p_use;
	mbfu_pkg::width_t    w_new;
	logic [AW-1:0]       acc_new;

	always_comb begin
		base_phase   = busy_q ? phase_post : phase_q;
		base_counter = busy_q ? counter_post : counter_q;
		base_n       = busy_q ? n_post : n_q;
		base_p       = (mbfu_pkg::phase_open(base_phase) && base_n < 6'd16) ?
			base_n[3:0] : 4'd0;
		new_phase    = record_start ? mbfu_pkg::PH_FIRST : base_phase;
		new_counter  = record_start ? 6'd0 : base_counter;
		p_raw        = record_start ? 4'd0 : base_p;
		w_new = mbfu_pkg::clamp_width((new_phase == mbfu_pkg::PH_SECOND) ?
			second_width_q : first_width_q);
		// drop held bits that no longer fit below the field width
		p_use   = ({1'b0, p_raw} >= w_new) ? 4'd0 : p_raw;
		acc_new = {acc_q[mbfu_pkg::HOLD_MAX-1:0] & mbfu_pkg::hold_mask(p_use), word_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			phase_q   <= mbfu_pkg::PH_IDLE;
			counter_q <= 6'd0;
			emit_q    <= 5'd0;
			n_q       <= 6'd0;
		end else if (accept) begin
			phase_q   <= new_phase;
			counter_q <= new_counter;
			emit_q    <= 5'd0;
			busy_q    <= mbfu_pkg::phase_open(new_phase);
			n_q       <= {2'b00, p_use} + 6'(mbfu_pkg::WORD_WIDTH);
		end else if (fire) begin
			phase_q   <= phase_post;
			counter_q <= counter_post;
			emit_q    <= emit_q + 5'd1;
			busy_q    <= more;
			n_q       <= n_post;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mbfu_pkg::phase_open(new_phase)) begin
			acc_q <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			field_value_q  <= value;
			table_select_q <= second;
			field_index_q  <= counter_q;
			last_q         <= !more;
			done_q         <= second && table_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign field_value  = field_value_q;
	assign table_select = table_select_q;
	assign field_index  = field_index_q;
	assign last_of_word = last_q;
	assign record_done  = done_q;

	a_busy_open: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> mbfu_pkg::phase_open(phase_q))
		else $error("extractor busy outside an open table");

	a_window_fits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (n_q >= {1'b0, w_cur}))
		else $error("window holds fewer bits than the field width");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (last_q && table_select_q))
		else $error("record done without last-of-word on a second-table field");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> busy_q)
		else $error("input held off while the extractor is free");

endmodule
